### rtl/hcbp_pkg.sv
// Shared types and constants for the code bit packer.
// Holds command codes, controller states and the controller/datapath bundles.
// No dependencies.
package hcbp_pkg;

	// Field widths of one input and one output transaction
	localparam int CMD_W       = 2;
	localparam int SYM_W       = 8;
	localparam int CODE_BITS_W = 32;
	localparam int CODE_LEN_W  = 6;
	localparam int BYTE_BITS   = 8;

	// Default configuration
	localparam int DEF_MAX_CODE_LEN  = 32;
	localparam int DEF_ALPHABET_SIZE = 256;

	// Command codes carried in the input tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_FLUSH  = 2'd2
	} cmd_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_STEP
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic flush;   // pad and emit the partial byte, empty the accumulator
		logic fetch;   // load the working code from the table read data
		logic step;    // emit one byte or merge the remaining bits
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic out_space;  // output register can take a byte this cycle
		logic need_emit;  // remaining code does not fit in the free bits
		logic last_emit;  // the byte emitted now is the final one of the item
	} dp_status_t;

endpackage

### rtl/huffman_code_bit_packer_unit.sv
// Variable-length code bit packer, top level.
// Joins hcbp_ctrl, hcbp_datapath and hcbp_code_table. Depends on hcbp_pkg.
//
// Input channel (s_*): one transaction is a command in s_tuser. A load writes
// one table entry (code and length) for the byte in symbol. An encode looks up
// the code of symbol and packs it, most significant bit first, into bytes. A
// flush pads the partial byte with zeros and emits it. Unused commands are
// dropped.
// Output channel (m_*): one packed byte per transaction; m_tlast marks the
// final byte produced by an input transaction.
// Sequencing: a load, a flush or an unused command is handled in the idle state.
// An encode emits N bytes (0 to 4): the registered table read, then the fetch
// that masks the code, then one byte per cycle, while the output register has
// space, through the output register, which holds one byte.
// Reset: the accumulator empties and every table entry reads as unused at
// once through per-entry valid bits; no clearing pass is needed.
// Stall: while m_tready is low the output byte holds, the emit sequence waits
// and s_tready stays low until the output register frees.
module huffman_code_bit_packer_unit #(
	parameter int MAX_CODE_LEN  = hcbp_pkg::DEF_MAX_CODE_LEN,
	parameter int ALPHABET_SIZE = hcbp_pkg::DEF_ALPHABET_SIZE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // symbol[7:0], code_bits[39:8], code_length[45:40], zero
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte[7:0]
	output logic        m_tlast
);

	localparam int CODE_W = (MAX_CODE_LEN < hcbp_pkg::CODE_BITS_W) ?
		MAX_CODE_LEN : hcbp_pkg::CODE_BITS_W;
	localparam int LEN_W  = $clog2(CODE_W + 1);

	hcbp_pkg::dp_cmd_t    dp_cmd;
	hcbp_pkg::dp_status_t dp_status;
	logic                 tbl_we;
	logic                 tbl_re;
	logic [CODE_W-1:0]    rd_code;
	logic [LEN_W-1:0]     rd_len;

	hcbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (s_tuser),
		.status   (dp_status),
		.dp_cmd   (dp_cmd),
		.tbl_we   (tbl_we),
		.tbl_re   (tbl_re)
	);

	hcbp_code_table #(
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.CODE_W        (CODE_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (tbl_we),
		.re      (tbl_re),
		.sym     (s_tdata[7:0]),
		.wr_code (s_tdata[39:8]),
		.wr_len  (s_tdata[45:40]),
		.rd_code (rd_code),
		.rd_len  (rd_len)
	);

	hcbp_datapath #(
		.CODE_W (CODE_W)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.status    (dp_status),
		.rd_code   (rd_code),
		.rd_len    (rd_len),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

### rtl/hcbp_code_table.sv
// Code table: code and length memories with per-entry valid bits.
// Registered read, one write port. Depends on hcbp_pkg.
module hcbp_code_table #(
	parameter int ALPHABET_SIZE = hcbp_pkg::DEF_ALPHABET_SIZE,
	parameter int CODE_W        = hcbp_pkg::DEF_MAX_CODE_LEN
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              we,
	input  logic                              re,
	input  logic [hcbp_pkg::SYM_W-1:0]        sym,
	input  logic [hcbp_pkg::CODE_BITS_W-1:0]  wr_code,
	input  logic [hcbp_pkg::CODE_LEN_W-1:0]   wr_len,
	output logic [CODE_W-1:0]                 rd_code,
	output logic [$clog2(CODE_W+1)-1:0]       rd_len
);

	localparam int IDX_W = $clog2(ALPHABET_SIZE);
	localparam int LEN_W = $clog2(CODE_W + 1);

	logic [CODE_W-1:0]                 code_mem [ALPHABET_SIZE];
	logic [LEN_W-1:0]                  len_mem  [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0]          valid_q;
	logic [CODE_W-1:0]                 rd_code_q;
	logic [LEN_W-1:0]                  rd_len_q;
	logic                              rd_hit_q;
	logic                              in_range;
	logic [IDX_W-1:0]                  idx;
	logic [hcbp_pkg::CODE_LEN_W-1:0]   len_sat;

	// Decode the symbol against the alphabet
	assign in_range = {1'b0, sym} < (hcbp_pkg::SYM_W + 1)'(ALPHABET_SIZE);
	assign idx      = sym[IDX_W-1:0];

	// Saturate overlong lengths to the widest storable code
	assign len_sat = (wr_len > hcbp_pkg::CODE_LEN_W'(CODE_W)) ?
		hcbp_pkg::CODE_LEN_W'(CODE_W) : wr_len;

	// Write an entry
	always_ff @(posedge clk) begin
		if (we && in_range) begin
			code_mem[idx] <= wr_code[CODE_W-1:0];
			len_mem[idx]  <= LEN_W'(len_sat);
		end
	end

	// Mark written entries; reset leaves every entry unused
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we && in_range) begin
			valid_q[idx] <= 1'b1;
		end
	end

	// Read an entry
	always_ff @(posedge clk) begin
		if (re) begin
			rd_code_q <= code_mem[idx];
			rd_len_q  <= len_mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_hit_q <= 1'b0;
		end else if (re) begin
			rd_hit_q <= in_range && valid_q[idx];
		end
	end

	// Unused or out-of-alphabet entries read as length zero
	assign rd_code = rd_code_q;
	assign rd_len  = rd_hit_q ? rd_len_q : '0;

endmodule

### rtl/hcbp_datapath.sv
// Datapath: bit accumulator, working code registers and output byte register.
// Driven by hcbp_ctrl commands. Depends on hcbp_pkg.
module hcbp_datapath #(
	parameter int CODE_W = hcbp_pkg::DEF_MAX_CODE_LEN
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hcbp_pkg::dp_cmd_t             cmd,
	output hcbp_pkg::dp_status_t          status,
	input  logic [CODE_W-1:0]             rd_code,
	input  logic [$clog2(CODE_W+1)-1:0]   rd_len,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hcbp_pkg::BYTE_BITS-1:0] out_byte,
	output logic                          out_last
);

	localparam int LEN_W = $clog2(CODE_W + 1);
	localparam int AW    = (LEN_W > 4) ? LEN_W : 4;

	logic [7:0]          acc_q;
	logic [3:0]          fr_q;
	logic [CODE_W-1:0]   code_q;
	logic [LEN_W-1:0]    len_q;
	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	logic                out_last_q;

	logic [AW-1:0]       len_x;
	logic [AW-1:0]       fr_x;
	logic [AW-1:0]       rest;
	logic                out_space;
	logic                need_emit;
	logic                last_emit;
	logic [CODE_W-1:0]   code_sh;
	logic [CODE_W+7:0]   code_sh_ext;
	logic [15:0]         acc_sh;
	logic [7:0]          emit_byte;
	logic [CODE_W-1:0]   code_rest;
	logic [CODE_W+7:0]   code_rest_ext;
	logic [CODE_W+7:0]   code_ext;
	logic [15:0]         acc_fin;
	logic [AW-1:0]       fr_after_emit;
	logic [CODE_W-1:0]   fetch_mask;
	logic                flush_emit;

	// Compare the remaining code length against the free bits
	assign len_x     = AW'(len_q);
	assign fr_x      = AW'(fr_q);
	assign rest      = len_x - fr_x;
	assign need_emit = fr_x < len_x;
	assign last_emit = rest <= AW'(8);
	assign out_space = !out_valid_q || out_ready;

	assign status.out_space = out_space;
	assign status.need_emit = need_emit;
	assign status.last_emit = last_emit;

	// Top the accumulator up with the leading code bits
	assign code_sh     = code_q >> rest;
	assign code_sh_ext = {8'b0, code_sh};
	assign acc_sh      = {8'b0, acc_q} << fr_q;
	assign emit_byte   = acc_sh[7:0] | code_sh_ext[7:0];

	// Keep the code bits not yet emitted
	assign code_rest     = code_q & ((CODE_W'(1) << rest) - CODE_W'(1));
	assign code_rest_ext = {8'b0, code_rest};
	assign fr_after_emit = AW'(8) - rest;

	// Merge a code that fits into the free bits
	assign code_ext = {8'b0, code_q};
	assign acc_fin  = ({8'b0, acc_q} << len_q) | {8'b0, code_ext[7:0]};

	// Drop code bits above the entry length
	assign fetch_mask = (CODE_W'(1) << rd_len) - CODE_W'(1);

	assign flush_emit = cmd.flush && (fr_q != 4'd8);

	// Working code registers
	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			code_q <= rd_code & fetch_mask;
			len_q  <= rd_len;
		end else if (cmd.step && need_emit) begin
			code_q <= code_rest;
			len_q  <= LEN_W'(rest);
		end
	end

	// Accumulator and free bit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			fr_q  <= 4'd8;
		end else if (cmd.flush) begin
			acc_q <= '0;
			fr_q  <= 4'd8;
		end else if (cmd.step) begin
			if (!need_emit) begin
				acc_q <= acc_fin[7:0];
				fr_q  <= fr_q - 4'(len_q);
			end else if (last_emit) begin
				acc_q <= code_rest_ext[7:0];
				fr_q  <= 4'(fr_after_emit);
			end else begin
				acc_q <= '0;
				fr_q  <= 4'd8;
			end
		end
	end

	// Output register: load a byte, clear once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (flush_emit || (cmd.step && need_emit)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (flush_emit) begin
			out_byte_q <= acc_sh[7:0];
			out_last_q <= 1'b1;
		end else if (cmd.step && need_emit) begin
			out_byte_q <= emit_byte;
			out_last_q <= last_emit;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	// Free bit count stays within one byte
	assert property (@(posedge clk) disable iff (!arst_n) fr_q <= 4'd8)
		else $error("free bit count above eight");

	// A byte is produced only when the output register can take it
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && need_emit) |-> out_space)
		else $error("byte produced into a full output register");

	// A non-final byte leaves more than a byte of code to emit
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && need_emit && !last_emit) |=> need_emit)
		else $error("emission ended before the final byte");

	// A flush always empties the accumulator
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> (fr_q == 4'd8 && acc_q == 8'd0))
		else $error("accumulator not empty after flush");

endmodule

### rtl/hcbp_ctrl.sv
// Controller: sequences table loads, lookups, byte emission and flushes.
// Talks to hcbp_datapath and hcbp_code_table. Depends on hcbp_pkg.
module hcbp_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [hcbp_pkg::CMD_W-1:0] in_cmd,
	input  hcbp_pkg::dp_status_t       status,
	output hcbp_pkg::dp_cmd_t          dp_cmd,
	output logic                       tbl_we,
	output logic                       tbl_re
);

	hcbp_pkg::state_t state_q;
	hcbp_pkg::state_t state_d;
	logic             accept;
	logic             is_load;
	logic             is_encode;
	logic             is_flush;

	// Decode the incoming command
	always_comb begin
		is_load   = 1'b0;
		is_encode = 1'b0;
		is_flush  = 1'b0;
		case (in_cmd)
			hcbp_pkg::CMD_LOAD:   is_load   = 1'b1;
			hcbp_pkg::CMD_ENCODE: is_encode = 1'b1;
			hcbp_pkg::CMD_FLUSH:  is_flush  = 1'b1;
			default: ;
		endcase
	end

	assign in_ready = (state_q == hcbp_pkg::ST_IDLE) && status.out_space;
	assign accept   = in_valid && in_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hcbp_pkg::ST_IDLE: begin
				if (accept && is_encode) state_d = hcbp_pkg::ST_FETCH;
			end
			hcbp_pkg::ST_FETCH: begin
				state_d = hcbp_pkg::ST_STEP;
			end
			hcbp_pkg::ST_STEP: begin
				if (!status.need_emit) begin
					state_d = hcbp_pkg::ST_IDLE;
				end else if (status.out_space && status.last_emit) begin
					state_d = hcbp_pkg::ST_IDLE;
				end
			end
			default: state_d = hcbp_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		dp_cmd = '0;
		tbl_we = 1'b0;
		tbl_re = 1'b0;
		case (state_q)
			hcbp_pkg::ST_IDLE: begin
				tbl_we       = accept && is_load;
				tbl_re       = accept && is_encode;
				dp_cmd.flush = accept && is_flush;
			end
			hcbp_pkg::ST_FETCH: begin
				dp_cmd.fetch = 1'b1;
			end
			hcbp_pkg::ST_STEP: begin
				dp_cmd.step = !status.need_emit || status.out_space;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hcbp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### verif/tb_top.sv
// Self-checking testbench for huffman_code_bit_packer_unit.
// Loads code table entries, encodes and flushes over the stream ports and checks
// every packed byte against a cycle-free model of the packer. Depends on hcbp_pkg.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         DRAIN_WAIT  = 12;
	localparam int         HOLD_CYCLES = 300;

	// One packed byte as the block should emit it
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_byte_t;

	// Tracks table, accumulator and the bytes still owed by the block
	class packed_byte_checker;
		logic [31:0] code_tab [256];
		logic [5:0]  len_tab [256];
		logic [7:0]  acc;
		int unsigned free_cnt;
		out_byte_t   expected_bytes [$];
		int          errors;

		function new();
			foreach (code_tab[k]) begin
				code_tab[k] = '0;
				len_tab[k]  = '0;
			end
			acc      = '0;
			free_cnt = hcbp_pkg::BYTE_BITS;
			errors   = 0;
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		function void push_byte(logic [63:0] value);
			out_byte_t b;
			b.data = value[7:0];
			b.last = 1'b0;
			expected_bytes.push_back(b);
		endfunction

		// Append one code to the accumulator, emitting every byte that must make room
		function void pack_code(logic [7:0] sym);
			int unsigned n, fr, rest, emitted;
			logic [63:0] code, a;
			n       = len_tab[sym];
			emitted = 0;
			if (n == 0)
				return;
			code = {32'b0, code_tab[sym]} & ((64'd1 << n) - 64'd1);
			a    = {56'b0, acc};
			fr   = free_cnt;
			while (fr < n && emitted < 4) begin
				rest = n - fr;
				push_byte((a << fr) | (code >> rest));
				emitted++;
				code &= (64'd1 << rest) - 64'd1;
				n    = rest;
				a    = '0;
				fr   = hcbp_pkg::BYTE_BITS;
			end
			a        = ((a << n) | code) & 64'hFF;
			acc      = a[7:0];
			free_cnt = fr - n;
		endfunction

		// Note one accepted command and queue the bytes it causes
		function void accept_command(logic [1:0] cmd, logic [7:0] sym, logic [31:0] bits,
				logic [5:0] len);
			int start_cnt;
			logic [15:0] padded;
			start_cnt = expected_bytes.size();
			case (cmd)
				hcbp_pkg::CMD_LOAD: begin
					code_tab[sym] = bits;
					len_tab[sym]  = (len > 6'd32) ? 6'd32 : len;
				end
				hcbp_pkg::CMD_ENCODE: begin
					pack_code(sym);
				end
				hcbp_pkg::CMD_FLUSH: begin
					if (free_cnt < hcbp_pkg::BYTE_BITS) begin
						padded = {8'b0, acc} << free_cnt;
						push_byte({48'b0, padded});
					end
					acc      = '0;
					free_cnt = hcbp_pkg::BYTE_BITS;
				end
				default: ;
			endcase
			if (expected_bytes.size() > start_cnt)
				expected_bytes[expected_bytes.size() - 1].last = 1'b1;
		endfunction

		task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
			$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
			errors++;
		endtask

		// Compare one output transaction with the oldest expected byte
		task check_byte(logic [7:0] data, logic last);
			out_byte_t want;
			if (expected_bytes.size() == 0) begin
				report_mismatch("unexpected byte", data, 8'h00);
				return;
			end
			want = expected_bytes.pop_front();
			if (data !== want.data)
				report_mismatch("out_byte", data, want.data);
			if (last !== want.last)
				report_mismatch("last", {7'b0, last}, {7'b0, want.last});
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // symbol[7:0], code_bits[39:8], code_length[45:40], zero
	logic [1:0]  s_tuser;   // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // out_byte[7:0]
	logic        m_tlast;

	packed_byte_checker packer_chk;
	int                 send_idle_pct;
	int                 recv_idle_pct;
	logic               hold_rx;
	int unsigned        cycle_count;

	huffman_code_bit_packer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Offer one command and wait until it is taken; valid may drop between items at random, per send_idle_pct
	task automatic send_cmd(logic [1:0] cmd, logic [7:0] sym, logic [31:0] bits,
			logic [5:0] len);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {2'b00, len, bits, sym};
		do
			@(posedge clk);
		while (!s_tready);
		packer_chk.accept_command(cmd, sym, bits, len);
	endtask

	// Pick a symbol, mostly from a small hot set so encodes hit loaded entries
	function automatic logic [7:0] pick_symbol();
		if ($urandom_range(99) < 60)
			return 8'($urandom_range(15));
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [5:0] pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return 6'd0;
		if (r < 12)
			return 6'($urandom_range(63, 33));
		if (r < 50)
			return 6'($urandom_range(8, 1));
		return 6'($urandom_range(32, 1));
	endfunction

	task automatic send_random(int count);
		int r;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 15)
				send_cmd(hcbp_pkg::CMD_LOAD, pick_symbol(), $urandom, pick_length());
			else if (r < 85)
				send_cmd(hcbp_pkg::CMD_ENCODE, pick_symbol(), $urandom,
					6'($urandom_range(63)));
			else if (r < 97)
				send_cmd(hcbp_pkg::CMD_FLUSH, 8'($urandom_range(255)), $urandom,
					6'($urandom_range(63)));
			else
				send_cmd(CMD_UNUSED, 8'($urandom_range(255)), $urandom,
					6'($urandom_range(63)));
		end
	endtask

	// Output side: check each transaction, then decide next cycle's ready
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				packer_chk.check_byte(m_tdata, m_tlast);
			m_tready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Abort a run that goes on past the cycle limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top failed");
		$finish;
	end

	initial begin
		packer_chk    = new();
		send_idle_pct = 28;
		recv_idle_pct = 62;
		hold_rx       = 1'b0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tuser       = '0;
		s_tdata       = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed: empty flush, unused entry, saturation, exact fill, four-byte code
		send_cmd(hcbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0);
		send_cmd(hcbp_pkg::CMD_ENCODE, 8'h05, 32'h0, 6'd0);
		send_cmd(hcbp_pkg::CMD_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd63);
		send_cmd(hcbp_pkg::CMD_LOAD, 8'hFF, 32'hFFFF_FFA5, 6'd8);
		send_cmd(hcbp_pkg::CMD_LOAD, 8'h01, 32'hFFFF_FFFE, 6'd1);
		send_cmd(hcbp_pkg::CMD_LOAD, 8'h02, 32'h0000_0005, 6'd3);
		send_cmd(hcbp_pkg::CMD_LOAD, 8'h03, 32'h0, 6'd0);
		send_cmd(hcbp_pkg::CMD_ENCODE, 8'hFF, 32'h0, 6'd0);
		send_cmd(hcbp_pkg::CMD_ENCODE, 8'h02, 32'h0, 6'd0);
		send_cmd(hcbp_pkg::CMD_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'd63);
		send_cmd(hcbp_pkg::CMD_ENCODE, 8'h03, 32'h0, 6'd0);
		send_cmd(hcbp_pkg::CMD_ENCODE, 8'h01, 32'h0, 6'd0);
		send_cmd(hcbp_pkg::CMD_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63);
		send_cmd(hcbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0);
		send_cmd(CMD_UNUSED, 8'hAA, 32'h5555_AAAA, 6'd42);
		send_cmd(hcbp_pkg::CMD_LOAD, 8'h80, 32'h1234_5678, 6'd32);
		send_cmd(hcbp_pkg::CMD_ENCODE, 8'h80, 32'h0, 6'd0);
		send_cmd(hcbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0);
		send_cmd(hcbp_pkg::CMD_LOAD, 8'h55, 32'hDEAD_BEEF, 6'd33);
		send_cmd(hcbp_pkg::CMD_ENCODE, 8'h01, 32'h0, 6'd0);
		send_cmd(hcbp_pkg::CMD_ENCODE, 8'h55, 32'h0, 6'd0);
		send_cmd(hcbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0);

		send_random(117);
		send_idle_pct = 62;
		recv_idle_pct = 28;
		send_random(117);

		// No idling; stall the output for a long stretch while input keeps coming
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fork
			begin
				repeat (5) @(posedge clk);
				hold_rx <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx <= 1'b0;
			end
		join_none
		send_random(116);
		send_cmd(hcbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0);
		s_tvalid <= 1'b0;

		// Drain, then allow stray bytes to show up
		while (packer_chk.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (packer_chk.errors == 0 && packer_chk.pending() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

### files.f
rtl/hcbp_pkg.sv
rtl/hcbp_code_table.sv
rtl/hcbp_datapath.sv
rtl/hcbp_ctrl.sv
rtl/huffman_code_bit_packer_unit.sv
verif/tb_top.sv
